// ===== hw/rtl/c2spr_pkg.sv =====
// shared types and constants for the co2 sample parser with ring maximum
package c2spr_pkg;

  // stream payload widths
  localparam int S_TDATA_W = 32;
  localparam int S_TUSER_W = 2;
  localparam int M_TDATA_W = 32;
  localparam int M_TUSER_W = 1;

  // field widths
  localparam int BYTE_W   = 8;
  localparam int WIN_W    = 10;
  localparam int VALUE_W  = 17;
  localparam int ERR_W    = 2;
  localparam int SLOT_W   = 10;
  localparam int CFG_W    = 10;
  localparam int ACC_W    = 17;
  localparam int PROD_W   = ACC_W + CFG_W;

  // apb
  localparam int APB_AW = 3;
  localparam int APB_DW = 32;

  // register indexes (paddr[2])
  localparam logic REG_MULTIPLIER = 1'b0;
  localparam logic REG_LAST_INDEX = 1'b1;

  // input item modes (tuser)
  localparam logic [1:0] MODE_BYTE    = 2'd0;
  localparam logic [1:0] MODE_TIMEOUT = 2'd1;
  localparam logic [1:0] MODE_QUERY   = 2'd2;

  // result kinds
  localparam logic KIND_SAMPLE = 1'b0;
  localparam logic KIND_ANSWER = 1'b1;

  // error codes
  localparam logic [ERR_W-1:0] ERR_NONE    = 2'd0;
  localparam logic [ERR_W-1:0] ERR_NO_DATA = 2'd1;
  localparam logic [ERR_W-1:0] ERR_RANGE   = 2'd2;

  // parser constants
  localparam logic [BYTE_W-1:0]  START_LETTER = 8'h7A;
  localparam logic [BYTE_W-1:0]  DIGIT_LO     = 8'h30;
  localparam logic [BYTE_W-1:0]  DIGIT_HI     = 8'h39;
  localparam logic [ACC_W-1:0]   ACC_CAP      = 17'd100000;
  localparam logic [VALUE_W-1:0] VALUE_MAX    = 17'd99999;

  // register reset values
  localparam logic [CFG_W-1:0] MULT_RESET = 10'd1;
  localparam logic [CFG_W-1:0] LAST_RESET = 10'd1023;

endpackage

// ===== hw/rtl/c2spr_ring.sv =====
// sample ring memory with fill count, registered read that reads unwritten slots as zero
module c2spr_ring #(
  parameter int DEPTH = 1024,
  parameter int AW    = 10
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          wr_en,
  input  logic [AW-1:0]                 wr_addr,
  input  logic [c2spr_pkg::VALUE_W-1:0] wr_data,
  input  logic                          rd_en,
  input  logic [AW-1:0]                 rd_addr,
  output logic [c2spr_pkg::VALUE_W-1:0] rd_data
);
  import c2spr_pkg::*;

  logic [VALUE_W-1:0] mem [DEPTH];
  logic [VALUE_W-1:0] q;
  logic               q_ok;
  logic [AW:0]        fill;

  // writes always start at slot zero and move up by one or wrap to zero,
  // so the written slots are always a prefix of the ring
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      q <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fill <= '0;
      q_ok <= 1'b0;
    end else begin
      if (wr_en && ({1'b0, wr_addr} >= fill)) begin
        fill <= {1'b0, wr_addr} + (AW+1)'(1);
      end
      if (rd_en) begin
        q_ok <= ({1'b0, rd_addr} < fill);
      end
    end
  end

  assign rd_data = q_ok ? q : '0;

endmodule

// ===== hw/rtl/co2_sample_parser_ring_max.sv =====
// top level: co2 serial sample parser, sample ring and window maximum query
//
// Each input beat carries a mode in tuser: a received serial byte, a sample
// timeout, or a window maximum query. A byte that produces no result is taken
// in idle and the block stays ready. A byte or timeout that ends a reading
// passes through accept, scale multiply and ring write, plus any wait for the
// output register; a timeout with no digits skips the multiply. A query scans
// the ring through one read port, one slot per cycle, with one shared compare;
// the read port and the compare set that scan rate. The block holds one
// result in its output register and accepts the next beat while that result
// waits; output back-pressure stalls it only when a second result is ready
// before the first is taken. The ring reads as zero after reset through a
// fill count, so there is no clearing pass. Registers (multiplier at 0x0,
// last_index at 0x4) must be written over the apb port only while the block
// is idle; the block itself does not enforce this.
module co2_sample_parser_ring_max #(
  parameter int RING_DEPTH = 1024
) (
  input  logic                            clk,
  input  logic                            rst,
  // apb configuration port
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [c2spr_pkg::APB_AW-1:0]    paddr,
  input  logic [c2spr_pkg::APB_DW-1:0]    pwdata,
  output logic [c2spr_pkg::APB_DW-1:0]    prdata,
  output logic                            pready,
  // input stream
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  // rx_byte[7:0], window_start[17:8], window_end[27:18], zero[31:28]
  input  logic [c2spr_pkg::S_TDATA_W-1:0] s_axis_tdata,
  // mode[1:0]
  input  logic [c2spr_pkg::S_TUSER_W-1:0] s_axis_tuser,
  // result stream
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  // value[16:0], error[18:17], slot[28:19], zero[31:29]
  output logic [c2spr_pkg::M_TDATA_W-1:0] m_axis_tdata,
  // kind[0]
  output logic [c2spr_pkg::M_TUSER_W-1:0] m_axis_tuser
);
  import c2spr_pkg::*;

  localparam int          AW        = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
  localparam int unsigned LastSlot  = RING_DEPTH - 1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_STORE,
    ST_SEG1,
    ST_SEG2,
    ST_DRAIN
  } state_t;

  typedef enum logic [1:0] {
    PH_HUNT,
    PH_SKIP,
    PH_DIGITS
  } phase_t;

  // configuration registers
  logic [CFG_W-1:0]   multiplier;
  logic [CFG_W-1:0]   last_index;

  // sequencer and parser state
  state_t             state;
  phase_t             phase;
  logic [ACC_W-1:0]   acc;
  logic [AW-1:0]      write_slot;
  logic [PROD_W-1:0]  prod;
  logic [ERR_W-1:0]   pend_err;

  // query scan
  logic [AW-1:0]      q_start;
  logic [AW-1:0]      q_end;
  logic [AW-1:0]      ptr;
  logic [VALUE_W-1:0] maxv;
  logic               rd_pending;

  // output register
  logic               out_valid;
  logic               out_kind;
  logic [VALUE_W-1:0] out_value;
  logic [ERR_W-1:0]   out_error;
  logic [SLOT_W-1:0]  out_slot;

  // unpacked input fields
  logic [1:0]         in_mode;
  logic [BYTE_W-1:0]  in_byte;
  logic [WIN_W-1:0]   in_wstart;
  logic [WIN_W-1:0]   in_wend;

  logic               in_acc;
  logic               out_free;
  logic               is_digit;
  logic [3:0]         digit_val;
  logic [ACC_W+3:0]   acc_x10;
  logic [ACC_W-1:0]   acc_step;
  logic [AW-1:0]      win_s;
  logic [AW-1:0]      win_e;
  logic [AW-1:0]      last_eff;
  logic [AW:0]        ring_len;
  logic [AW:0]        bound1;
  logic [AW:0]        ptr_inc;
  logic [AW:0]        slot_inc;
  logic               over_range;
  logic [VALUE_W-1:0] store_val;
  logic [ERR_W-1:0]   store_err;

  // ring ports
  logic               wr_en;
  logic               rd_en;
  logic [VALUE_W-1:0] rd_data;
  logic [VALUE_W-1:0] mx;

  // ---------------------------------------------------------------- apb
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      multiplier <= MULT_RESET;
      last_index <= LAST_RESET;
    end else if (psel && penable && pwrite && pready) begin
      case (paddr[2])
        REG_MULTIPLIER: multiplier <= pwdata[CFG_W-1:0];
        REG_LAST_INDEX: last_index <= pwdata[CFG_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      REG_MULTIPLIER: prdata = APB_DW'(multiplier);
      REG_LAST_INDEX: prdata = APB_DW'(last_index);
      default:        prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------- fields
  assign in_mode   = s_axis_tuser;
  assign in_byte   = s_axis_tdata[7:0];
  assign in_wstart = s_axis_tdata[17:8];
  assign in_wend   = s_axis_tdata[27:18];

  assign s_axis_tready = (state == ST_IDLE);
  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign out_free      = !out_valid || m_axis_tready;

  // decimal digit step, saturating at the cap
  assign is_digit  = (in_byte >= DIGIT_LO) && (in_byte <= DIGIT_HI);
  assign digit_val = in_byte[3:0];
  assign acc_x10   = ((ACC_W+4)'(acc) << 3) + ((ACC_W+4)'(acc) << 1) + (ACC_W+4)'(digit_val);
  assign acc_step  = (acc_x10 > (ACC_W+4)'(ACC_CAP)) ? ACC_CAP : acc_x10[ACC_W-1:0];

  // window bounds saturate to the last ring slot
  assign win_s = (32'(in_wstart) > LastSlot) ? AW'(LastSlot) : AW'(in_wstart);
  assign win_e = (32'(in_wend) > LastSlot) ? AW'(LastSlot) : AW'(in_wend);

  // effective ring length
  assign last_eff = (32'(last_index) > LastSlot) ? AW'(LastSlot) : AW'(last_index);
  assign ring_len = {1'b0, last_eff} + (AW+1)'(1);
  assign slot_inc = {1'b0, write_slot} + (AW+1)'(1);

  // first scan segment always covers the start slot
  always_comb begin
    if (q_start < q_end) begin
      bound1 = {1'b0, q_end};
    end else if (q_start > q_end) begin
      bound1 = ring_len;
    end else begin
      bound1 = {1'b0, q_start} + (AW+1)'(1);
    end
  end
  assign ptr_inc = {1'b0, ptr} + (AW+1)'(1);

  // scaled reading check
  assign over_range = (prod > PROD_W'(VALUE_MAX));
  always_comb begin
    if (pend_err != ERR_NONE) begin
      store_val = '0;
      store_err = pend_err;
    end else if (over_range) begin
      store_val = '0;
      store_err = ERR_RANGE;
    end else begin
      store_val = prod[VALUE_W-1:0];
      store_err = ERR_NONE;
    end
  end

  // ---------------------------------------------------------------- ring
  assign wr_en = (state == ST_STORE) && out_free;
  assign rd_en = (state == ST_SEG1) || (state == ST_SEG2);

  c2spr_ring #(
    .DEPTH (RING_DEPTH),
    .AW    (AW)
  ) u_ring (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (wr_en),
    .wr_addr (write_slot),
    .wr_data (store_val),
    .rd_en   (rd_en),
    .rd_addr (ptr),
    .rd_data (rd_data)
  );

  // shared compare: running maximum over the returned slots
  assign mx = (rd_pending && (rd_data > maxv)) ? rd_data : maxv;

  // ---------------------------------------------------------------- sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      phase      <= PH_HUNT;
      acc        <= '0;
      write_slot <= '0;
      rd_pending <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        out_valid <= 1'b0;
      end
      rd_pending <= rd_en;
      maxv       <= mx;

      case (state)
        ST_IDLE: begin
          if (in_acc) begin
            case (in_mode)
              MODE_BYTE: begin
                case (phase)
                  PH_DIGITS: begin
                    if (is_digit) begin
                      acc <= acc_step;
                    end else begin
                      // reading ends; a start letter here opens the next one
                      phase    <= (in_byte == START_LETTER) ? PH_SKIP : PH_HUNT;
                      pend_err <= ERR_NONE;
                      state    <= ST_MUL;
                    end
                  end
                  PH_SKIP: begin
                    if (is_digit) begin
                      acc   <= ACC_W'(digit_val);
                      phase <= PH_DIGITS;
                    end
                  end
                  default: begin
                    if (in_byte == START_LETTER) begin
                      phase <= PH_SKIP;
                      acc   <= '0;
                    end
                  end
                endcase
              end
              MODE_TIMEOUT: begin
                phase <= PH_HUNT;
                case (phase)
                  PH_DIGITS: begin
                    pend_err <= ERR_NONE;
                    state    <= ST_MUL;
                  end
                  PH_SKIP: begin
                    // letter seen but no digits: zero without error
                    prod     <= '0;
                    pend_err <= ERR_NONE;
                    state    <= ST_STORE;
                  end
                  default: begin
                    prod     <= '0;
                    pend_err <= ERR_NO_DATA;
                    state    <= ST_STORE;
                  end
                endcase
              end
              MODE_QUERY: begin
                q_start <= win_s;
                q_end   <= win_e;
                ptr     <= win_s;
                maxv    <= '0;
                state   <= ST_SEG1;
              end
              default: ;
            endcase
          end
        end

        ST_MUL: begin
          prod  <= PROD_W'(acc) * PROD_W'(multiplier);
          state <= ST_STORE;
        end

        ST_STORE: begin
          if (out_free) begin
            out_valid  <= 1'b1;
            out_kind   <= KIND_SAMPLE;
            out_value  <= store_val;
            out_error  <= store_err;
            out_slot   <= SLOT_W'(write_slot);
            write_slot <= (slot_inc >= ring_len) ? '0 : slot_inc[AW-1:0];
            acc        <= '0;
            state      <= ST_IDLE;
          end
        end

        ST_SEG1: begin
          if (ptr_inc < bound1) begin
            ptr <= ptr_inc[AW-1:0];
          end else if ((q_start > q_end) && (q_end != '0)) begin
            // wrapping window continues from slot zero
            ptr   <= '0;
            state <= ST_SEG2;
          end else begin
            state <= ST_DRAIN;
          end
        end

        ST_SEG2: begin
          if (ptr_inc < {1'b0, q_end}) begin
            ptr <= ptr_inc[AW-1:0];
          end else begin
            state <= ST_DRAIN;
          end
        end

        ST_DRAIN: begin
          if (out_free) begin
            out_valid <= 1'b1;
            out_kind  <= KIND_ANSWER;
            out_value <= mx;
            out_error <= ERR_NONE;
            out_slot  <= '0;
            state     <= ST_IDLE;
          end
        end

        default: state <= ST_IDLE;
      endcase
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {3'b000, out_slot, out_error, out_value};
  assign m_axis_tuser  = out_kind;

endmodule

// ===== hw/rtl/c2spr_checker.sv =====
// port-level checker for the co2 sample parser with ring maximum, and its bind
module c2spr_checker (
  input logic                            clk,
  input logic                            rst,
  input logic                            s_axis_tvalid,
  input logic                            s_axis_tready,
  input logic [c2spr_pkg::S_TUSER_W-1:0] s_axis_tuser,
  input logic                            m_axis_tvalid,
  input logic                            m_axis_tready,
  input logic [c2spr_pkg::M_TDATA_W-1:0] m_axis_tdata,
  input logic [c2spr_pkg::M_TUSER_W-1:0] m_axis_tuser
);
  import c2spr_pkg::*;

  // a stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("result beat changed while stalled");

  // answers carry no error and no slot
  a_answer_clean: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && (m_axis_tuser == KIND_ANSWER) |->
      (m_axis_tdata[18:17] == ERR_NONE) && (m_axis_tdata[28:19] == '0))
    else $error("window answer with error or slot set");

  // a flagged sample stores zero
  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && (m_axis_tuser == KIND_SAMPLE) &&
      (m_axis_tdata[18:17] != ERR_NONE) |-> (m_axis_tdata[16:0] == '0))
    else $error("flagged sample with nonzero value");

  // every result value stays in range
  a_value_range: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> (m_axis_tdata[16:0] <= VALUE_MAX))
    else $error("result value above range");

  // a query keeps the block busy while it scans
  a_query_busy: assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready && (s_axis_tuser == MODE_QUERY) |=> !s_axis_tready)
    else $error("ready right after a query");

endmodule

bind co2_sample_parser_ring_max c2spr_checker u_c2spr_checker (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .s_axis_tuser  (s_axis_tuser),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);

// ===== test/co2_sample_parser_ring_max_tb.sv =====
// self-checking stream testbench for the co2 sample parser with ring maximum
`timescale 1ns / 1ps

module co2_sample_parser_ring_max_tb;
  import c2spr_pkg::*;

  localparam int RING_DEPTH = 1024;
  localparam int HALF_PERIOD = 6;
  localparam int RESET_CYCLES = 7;
  // quiet cycles before a register write
  localparam int CFG_SETTLE = 8;
  // a full-ring query plus margin, waited out at the end of the run
  localparam int DRAIN_PAUSE = RING_DEPTH + 16;
  // several times the longest correct stretch with no beat moving
  localparam int QUIET_LIMIT = 6000;
  localparam int PHASE_ITEMS = 72;

  // mode 3 is not decoded by the block; it must be swallowed silently
  localparam logic [1:0] MODE_UNUSED = 2'd3;

  localparam logic [APB_AW-1:0] ADDR_MULTIPLIER = {REG_MULTIPLIER, 2'b00};
  localparam logic [APB_AW-1:0] ADDR_LAST_INDEX = {REG_LAST_INDEX, 2'b00};

  typedef enum logic [1:0] {PH_HUNT, PH_SKIP, PH_DIGITS} parse_phase_t;

  typedef struct packed {
    logic               kind;
    logic [VALUE_W-1:0] value;
    logic [ERR_W-1:0]   err;
    logic [SLOT_W-1:0]  slot;
  } co2_result_t;

  logic clk = 1'b0;
  logic rst;
  logic psel, penable, pwrite;
  logic [APB_AW-1:0] paddr;
  logic [APB_DW-1:0] pwdata;
  logic [APB_DW-1:0] prdata;
  logic pready;
  logic s_axis_tvalid, s_axis_tready;
  logic [S_TDATA_W-1:0] s_axis_tdata;  // rx_byte[7:0], window_start[17:8], window_end[27:18]
  logic [S_TUSER_W-1:0] s_axis_tuser;  // mode[1:0]
  logic m_axis_tvalid, m_axis_tready;
  logic [M_TDATA_W-1:0] m_axis_tdata;  // value[16:0], error[18:17], slot[28:19]
  logic [M_TUSER_W-1:0] m_axis_tuser;  // kind[0]

  // shadow of the block: registers, parser state and the sample ring
  int unsigned mult_cfg;
  int unsigned last_cfg;
  parse_phase_t phase;
  int unsigned digit_acc;
  int unsigned write_ptr;
  int unsigned ring_copy [RING_DEPTH];

  co2_result_t pending_results[$];
  int unsigned mismatches;
  int unsigned beats_sent;
  int unsigned quiet_cycles;

  // knobs shared between the test tasks and the stream processes
  bit source_gaps_on;
  bit sink_stalls_on;
  int unsigned sink_hold_req;
  bit offering;

  co2_sample_parser_ring_max #(
    .RING_DEPTH(RING_DEPTH)
  ) u_dut (
    .clk(clk),
    .rst(rst),
    .psel(psel),
    .penable(penable),
    .pwrite(pwrite),
    .paddr(paddr),
    .pwdata(pwdata),
    .prdata(prdata),
    .pready(pready),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .s_axis_tuser(s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata),
    .m_axis_tuser(m_axis_tuser)
  );

  always begin
    #HALF_PERIOD clk = 1'b1;
    #HALF_PERIOD clk = 1'b0;
  end

  // ------------------------------------------------------------------
  // prediction
  // ------------------------------------------------------------------

  // effective ring length: last_index clamped to the ring, plus one
  function automatic int unsigned ring_len();
    return ((last_cfg < RING_DEPTH) ? last_cfg : RING_DEPTH - 1) + 1;
  endfunction

  // write one sample at the write pointer and advance it with wrap
  function automatic co2_result_t ring_store(input int unsigned v, input logic [ERR_W-1:0] e);
    co2_result_t r;
    r.kind = KIND_SAMPLE;
    r.value = VALUE_W'(v);
    r.err = e;
    r.slot = SLOT_W'(write_ptr);
    ring_copy[write_ptr] = v;
    write_ptr = (write_ptr + 1 >= ring_len()) ? 0 : write_ptr + 1;
    return r;
  endfunction

  // end of a reading: scale, range check, store, clear the accumulator
  function automatic co2_result_t scale_and_store();
    int unsigned scaled;
    co2_result_t r;
    scaled = digit_acc * mult_cfg;
    if (scaled > 32'(VALUE_MAX))
      r = ring_store(0, ERR_RANGE);
    else
      r = ring_store(scaled, ERR_NONE);
    digit_acc = 0;
    return r;
  endfunction

  // advance the shadow by one input beat; returns 1 when a result is due
  function automatic bit compute_co2_result(input logic [1:0] mode, input logic [7:0] rx,
                                            input logic [WIN_W-1:0] ws_in,
                                            input logic [WIN_W-1:0] we_in,
                                            output co2_result_t r);
    int unsigned ws, we, peak, i;
    bit is_digit;
    r = '0;
    is_digit = (rx >= DIGIT_LO) && (rx <= DIGIT_HI);
    case (mode)
      MODE_BYTE: begin
        if (phase == PH_DIGITS) begin
          if (is_digit) begin
            digit_acc = digit_acc * 10 + 32'(rx - DIGIT_LO);
            if (digit_acc > 32'(ACC_CAP)) digit_acc = 32'(ACC_CAP);
            return 1'b0;
          end
          // terminating byte may itself be a new start letter
          r = scale_and_store();
          phase = (rx == START_LETTER) ? PH_SKIP : PH_HUNT;
          return 1'b1;
        end
        if (phase == PH_SKIP) begin
          if (is_digit) begin
            digit_acc = 32'(rx - DIGIT_LO);
            phase = PH_DIGITS;
          end
          return 1'b0;
        end
        if (rx == START_LETTER) begin
          phase = PH_SKIP;
          digit_acc = 0;
        end
        return 1'b0;
      end
      MODE_TIMEOUT: begin
        if (phase == PH_HUNT)
          r = ring_store(0, ERR_NO_DATA);
        else if (phase == PH_SKIP)
          r = ring_store(0, ERR_NONE);
        else
          r = scale_and_store();
        phase = PH_HUNT;
        digit_acc = 0;
        return 1'b1;
      end
      MODE_QUERY: begin
        ws = (32'(ws_in) < RING_DEPTH) ? 32'(ws_in) : RING_DEPTH - 1;
        we = (32'(we_in) < RING_DEPTH) ? 32'(we_in) : RING_DEPTH - 1;
        peak = ring_copy[ws];
        if (ws < we) begin
          for (i = ws; i < we; i++)
            if (ring_copy[i] > peak) peak = ring_copy[i];
        end else if (ws > we) begin
          // wrapping window: tail of the live ring, then the head
          for (i = ws; i < ring_len() && i < RING_DEPTH; i++)
            if (ring_copy[i] > peak) peak = ring_copy[i];
          for (i = 0; i < we; i++)
            if (ring_copy[i] > peak) peak = ring_copy[i];
        end
        r.kind = KIND_ANSWER;
        r.value = VALUE_W'(peak);
        return 1'b1;
      end
      default: return 1'b0;
    endcase
  endfunction

  // ------------------------------------------------------------------
  // checking
  // ------------------------------------------------------------------

  task automatic report_mismatch(input string what, input longint got, input longint want);
    $display("%0t ns: mismatch in %s: got %0d, expected %0d", $time, what, got, want);
    mismatches++;
  endtask

  // input beats are predicted first; a result never leaves on the edge
  // that accepted the beat causing it, so the order here is safe
  always @(posedge clk) begin : co2_scoreboard
    co2_result_t predicted, observed;
    bit has_result;
    if (!rst) begin
      if (s_axis_tvalid && s_axis_tready) begin
        has_result = compute_co2_result(s_axis_tuser, s_axis_tdata[7:0], s_axis_tdata[17:8],
                                        s_axis_tdata[27:18], predicted);
        if (has_result) pending_results.push_back(predicted);
      end
      if (m_axis_tvalid && m_axis_tready) begin
        observed.kind = m_axis_tuser[0];
        observed.value = m_axis_tdata[16:0];
        observed.err = m_axis_tdata[18:17];
        observed.slot = m_axis_tdata[28:19];
        if (pending_results.size() == 0) begin
          report_mismatch("result beat with nothing pending, value", observed.value, 0);
        end else begin
          predicted = pending_results.pop_front();
          if (observed.kind !== predicted.kind)
            report_mismatch("kind", observed.kind, predicted.kind);
          if (observed.value !== predicted.value)
            report_mismatch("value", observed.value, predicted.value);
          if (observed.err !== predicted.err)
            report_mismatch("error", observed.err, predicted.err);
          if (observed.slot !== predicted.slot)
            report_mismatch("slot", observed.slot, predicted.slot);
        end
      end
    end
  end

  // watchdog: any beat on either stream or any apb write counts as progress
  always @(posedge clk) begin
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (psel && penable && pready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("%0t ns: no progress for %0d cycles", $time, QUIET_LIMIT);
      $display("co2_sample_parser_ring_max verification failed");
      $finish;
    end
  end

  // ------------------------------------------------------------------
  // stream drivers
  // ------------------------------------------------------------------

  // mostly short gaps, now and then a long one
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // result sink: random stalls, or a long counted hold-off on request
  initial begin
    int unsigned n;
    m_axis_tready = 1'b0;
    forever begin
      if (sink_hold_req != 0) begin
        n = sink_hold_req;
        sink_hold_req = 0;
      end else begin
        n = sink_stalls_on ? pick_gap() : 0;
      end
      if (n > 0) begin
        m_axis_tready <= 1'b0;
        repeat (n) @(posedge clk);
      end
      m_axis_tready <= 1'b1;
      @(posedge clk);
    end
  end

  // drop tvalid only when it is up, so no signal gets two updates in a step
  task automatic stream_idle();
    if (offering) begin
      s_axis_tvalid <= 1'b0;
      offering = 1'b0;
    end
  endtask

  // offer one beat after an optional gap and hold it until accepted;
  // tvalid stays up afterwards so back-to-back beats need no bubble
  task automatic send_item(input logic [1:0] mode, input logic [7:0] rx,
                           input logic [WIN_W-1:0] ws, input logic [WIN_W-1:0] we);
    int unsigned gap;
    gap = source_gaps_on ? pick_gap() : 0;
    if (gap > 0) begin
      stream_idle();
      repeat (gap) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {4'b0000, we, ws, rx};
    s_axis_tuser <= mode;
    offering = 1'b1;
    do @(posedge clk); while (!s_axis_tready);
    beats_sent++;
  endtask

  // unused fields carry random bits so they are seen to be ignored
  task automatic send_byte(input logic [7:0] b);
    send_item(MODE_BYTE, b, WIN_W'($urandom_range(0, 1023)), WIN_W'($urandom_range(0, 1023)));
  endtask

  task automatic send_timeout();
    send_item(MODE_TIMEOUT, 8'($urandom_range(0, 255)), WIN_W'($urandom_range(0, 1023)),
              WIN_W'($urandom_range(0, 1023)));
  endtask

  // half the windows sit in the live ring, half span the whole field range
  task automatic send_query();
    if ($urandom_range(0, 1))
      send_item(MODE_QUERY, 8'($urandom_range(0, 255)), WIN_W'($urandom_range(0, last_cfg)),
                WIN_W'($urandom_range(0, last_cfg)));
    else
      send_item(MODE_QUERY, 8'($urandom_range(0, 255)), WIN_W'($urandom_range(0, 1023)),
                WIN_W'($urandom_range(0, 1023)));
  endtask

  function automatic logic [7:0] random_non_digit();
    logic [7:0] b;
    do b = 8'($urandom_range(0, 255)); while (b >= DIGIT_LO && b <= DIGIT_HI);
    return b;
  endfunction

  // a well-formed reading with random content and a random terminator
  task automatic send_reading();
    int unsigned digits;
    send_byte(START_LETTER);
    if ($urandom_range(0, 3) == 0)
      repeat ($urandom_range(1, 2)) send_byte(random_non_digit());
    digits = ($urandom_range(0, 3) == 0) ? $urandom_range(4, 6) : $urandom_range(1, 3);
    repeat (digits) send_byte(DIGIT_LO + 8'($urandom_range(0, 9)));
    case ($urandom_range(0, 9))
      0, 1, 2: send_timeout();
      3, 4:    send_byte(START_LETTER);
      default: send_byte(random_non_digit());
    endcase
  endtask

  // sender pauses until every predicted result has come back
  task automatic wait_drain();
    stream_idle();
    do @(posedge clk); while (pending_results.size() != 0);
  endtask

  // apb write: setup, access, then idle before the next transfer
  task automatic write_register(input logic [APB_AW-1:0] addr, input logic [APB_DW-1:0] data);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= addr;
    pwdata <= data;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
    if (addr == ADDR_MULTIPLIER)
      mult_cfg = 32'(data[CFG_W-1:0]);
    else if (addr == ADDR_LAST_INDEX)
      last_cfg = 32'(data[CFG_W-1:0]);
  endtask

  task automatic reconfigure(input int unsigned mult, input int unsigned last);
    wait_drain();
    repeat (CFG_SETTLE) @(posedge clk);
    write_register(ADDR_MULTIPLIER, mult);
    write_register(ADDR_LAST_INDEX, last);
  endtask

  // ------------------------------------------------------------------
  // tests
  // ------------------------------------------------------------------

  // parser corners at reset settings: timeouts in each phase, skipped
  // non-digits, the largest valid reading, a start letter ending a reading,
  // a partial reading and accumulator saturation into the range error
  task automatic test_parser_cases();
    send_byte(8'hFF);
    send_timeout();                    // hunting: no data error
    send_byte(START_LETTER);
    send_timeout();                    // start seen, no digits: zero, no error
    send_byte(START_LETTER);
    send_byte(":");
    repeat (5) send_byte("9");
    send_byte(START_LETTER);           // stores 99999 and starts skipping
    send_byte("1");
    send_timeout();                    // partial reading stored
    send_byte(START_LETTER);
    repeat (6) send_byte("9");         // saturates at the cap
    send_byte(" ");                    // cap scales out of range
  endtask

  // equal, wrapping and clamped windows, plus the unused mode
  task automatic test_query_windows();
    send_item(MODE_UNUSED, 8'h5A, 10'h3FF, 10'h000);
    send_item(MODE_QUERY, 8'h00, 10'd2, 10'd2);
    send_item(MODE_QUERY, 8'h00, 10'd3, 10'd1);
    send_item(MODE_QUERY, 8'h00, 10'd1023, 10'd0);
    send_item(MODE_QUERY, 8'h00, 10'd0, 10'd1023);
  endtask

  // sink holds off while the source keeps pushing, so the block backs up
  task automatic test_output_holdoff();
    source_gaps_on = 1'b0;
    sink_hold_req = 400;
    repeat (6) send_reading();
    repeat (4) send_timeout();
    repeat (2) send_query();
    source_gaps_on = 1'b1;
  endtask

  task automatic test_drain_then_resume();
    repeat (4) send_reading();
    wait_drain();
    repeat (3) send_query();
    repeat (2) send_reading();
  endtask

  // phases across register settings, extremes included; mostly readings,
  // the rest queries, timeouts, stray bytes and the unused mode
  task automatic test_random_traffic();
    int unsigned mult_set [6] = '{1, 0, 1023, 1000, 7, 1};
    int unsigned last_set [6] = '{1023, 3, 0, 1023, 15, 0};
    int unsigned useful, sent_before, pick, p;
    for (p = 0; p < 6; p++) begin
      if (p == 5) begin
        mult_set[p] = $urandom_range(1, 1000);
        last_set[p] = $urandom_range(0, 63);
      end
      reconfigure(mult_set[p], last_set[p]);
      // one phase runs flat out on both sides
      source_gaps_on = (p != 3) && (p != 5);
      sink_stalls_on = (p != 3);
      useful = 0;
      while (useful < PHASE_ITEMS) begin
        sent_before = beats_sent;
        pick = $urandom_range(0, 99);
        if (pick < 55)
          send_reading();
        else if (pick < 67)
          send_query();
        else if (pick < 77)
          send_timeout();
        else if (pick < 93)
          send_byte(8'($urandom_range(0, 255)));
        else
          send_item(MODE_UNUSED, 8'($urandom_range(0, 255)), WIN_W'($urandom_range(0, 1023)),
                    WIN_W'($urandom_range(0, 1023)));
        if (pick < 77) useful += beats_sent - sent_before;
      end
    end
    source_gaps_on = 1'b1;
    sink_stalls_on = 1'b1;
  endtask

  initial begin
    int i;
    rst = 1'b1;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    s_axis_tuser = '0;
    offering = 1'b0;
    source_gaps_on = 1'b1;
    sink_stalls_on = 1'b1;
    sink_hold_req = 0;
    mismatches = 0;
    beats_sent = 0;
    // shadow starts from the reset state
    mult_cfg = 32'(MULT_RESET);
    last_cfg = 32'(LAST_RESET);
    phase = PH_HUNT;
    digit_acc = 0;
    write_ptr = 0;
    for (i = 0; i < RING_DEPTH; i++) ring_copy[i] = 0;

    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_parser_cases();
    test_query_windows();
    test_output_holdoff();
    test_drain_then_resume();
    test_random_traffic();

    // let any late or extra result show up before judging
    wait_drain();
    repeat (DRAIN_PAUSE) @(posedge clk);
    if (pending_results.size() != 0)
      report_mismatch("results never delivered, count", pending_results.size(), 0);
    if (mismatches == 0)
      $display("co2_sample_parser_ring_max verification clean");
    else
      $display("co2_sample_parser_ring_max verification failed");
    $finish;
  end

endmodule
